FILE: rtl/histogram_equalization_lut_top_assert.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef HISTOGRAM_EQUALIZATION_LUT_TOP_ASSERT_SVH
`define HISTOGRAM_EQUALIZATION_LUT_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HEL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HEL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hel_pkg.sv
// ----------------------------------------------------------------------------
// hel_pkg
// Types and constants shared by the equalization table generator.
// ----------------------------------------------------------------------------
package hel_pkg;

	// How the back end produces the table entry
	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_SAT,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  level;
		logic        last;
	} ctrl_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_CHK,
		B_DIV,
		B_DONE
	} bstate_t;

	localparam logic [7:0] OUT_MAX = 8'd255;
	localparam int         QBITS   = 8;   // quotient bits below the saturation test
	localparam int         SCALE_SH = 9;  // 510*n = (n << 9) - (n << 1)
	localparam int         QPTR_W  = 1;   // queue of two entries

endpackage

FILE: rtl/hel_front.sv
// ----------------------------------------------------------------------------
// hel_front
// Accepts bin counts, keeps the running sum and minimum, and classifies each
// entry as zero, saturated or needing a division.
// ----------------------------------------------------------------------------
module hel_front #(
	parameter int NUM_LEVELS = 256,
	parameter int COUNT_BITS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COUNT_BITS-1:0] bin_count,
	input  logic [COUNT_BITS-1:0] pixel_count,
	output logic                  push_valid,
	input  logic                  push_ready,
	output hel_pkg::ctrl_t        push_ctrl,
	output logic [COUNT_BITS-1:0] push_num,
	output logic [COUNT_BITS-1:0] push_den
);

	localparam int LVL_W = $clog2(NUM_LEVELS);

	logic [COUNT_BITS-1:0] sum_q, first_q;
	logic                  seen_q;
	logic [LVL_W-1:0]      lvl_q;

	logic                  valid_s1, seen_s1, last_s1;
	logic [COUNT_BITS-1:0] sum_s1, first_s1, pix_s1;
	logic [7:0]            lvl_s1;

	logic [COUNT_BITS:0]   sum_ext;
	logic [COUNT_BITS-1:0] sum_new, first_new;
	logic                  take_first, last, accept;
	logic [LVL_W+7:0]      lvl_wide;
	logic [COUNT_BITS-1:0] num, den;

	assign accept     = in_valid && in_ready;
	assign in_ready   = !valid_s1 || push_ready;
	assign sum_ext    = {1'b0, sum_q} + {1'b0, bin_count};
	assign sum_new    = sum_ext[COUNT_BITS] ? '1 : sum_ext[COUNT_BITS-1:0];
	assign take_first = !seen_q && (sum_new != '0);
	assign first_new  = take_first ? sum_new : first_q;
	assign last       = (lvl_q == LVL_W'(NUM_LEVELS - 1));
	assign lvl_wide   = {8'd0, lvl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			first_q  <= '0;
			seen_q   <= 1'b0;
			lvl_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				// clear the table state after the last level
				if (last) begin
					sum_q   <= '0;
					first_q <= '0;
					seen_q  <= 1'b0;
					lvl_q   <= '0;
				end else begin
					sum_q   <= sum_new;
					first_q <= first_new;
					seen_q  <= seen_q | take_first;
					lvl_q   <= lvl_q + 1'b1;
				end
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1   <= sum_new;
			first_s1 <= first_new;
			seen_s1  <= seen_q | take_first;
			pix_s1   <= pixel_count;
			lvl_s1   <= lvl_wide[7:0];
			last_s1  <= last;
		end
	end

	assign num = sum_s1 - first_s1;
	assign den = pix_s1 - first_s1;

	always_comb begin
		push_ctrl.level = lvl_s1;
		push_ctrl.last  = last_s1;
		if (!seen_s1 || (pix_s1 == first_s1) || (num == '0)) begin
			push_ctrl.kind = hel_pkg::KIND_ZERO;
		end else if (pix_s1 < first_s1) begin
			push_ctrl.kind = hel_pkg::KIND_SAT;
		end else begin
			push_ctrl.kind = hel_pkg::KIND_DIV;
		end
	end

	assign push_valid = valid_s1;
	assign push_num   = num;
	assign push_den   = den;

endmodule

FILE: rtl/hel_queue.sv
// ----------------------------------------------------------------------------
// hel_queue
// Two-entry queue between the classifying front end and the divider.
// ----------------------------------------------------------------------------
module hel_queue #(
	parameter int DATA_W = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  hel_pkg::ctrl_t    push_ctrl,
	input  logic [DATA_W-1:0] push_num,
	input  logic [DATA_W-1:0] push_den,
	output logic              pop_valid,
	input  logic              pop_ready,
	output hel_pkg::ctrl_t    pop_ctrl,
	output logic [DATA_W-1:0] pop_num,
	output logic [DATA_W-1:0] pop_den
);

	localparam int DEPTH = 2 ** hel_pkg::QPTR_W;

	hel_pkg::ctrl_t            ctrl_q [DEPTH];
	logic [DATA_W-1:0]         num_q  [DEPTH];
	logic [DATA_W-1:0]         den_q  [DEPTH];
	logic [hel_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [hel_pkg::QPTR_W:0]   count_q;
	logic                       do_push, do_pop;

	assign push_ready = (count_q != (hel_pkg::QPTR_W + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctrl_q[wr_ptr_q] <= push_ctrl;
			num_q[wr_ptr_q]  <= push_num;
			den_q[wr_ptr_q]  <= push_den;
		end
	end

	assign pop_ctrl = ctrl_q[rd_ptr_q];
	assign pop_num  = num_q[rd_ptr_q];
	assign pop_den  = den_q[rd_ptr_q];

endmodule

FILE: rtl/hel_back.sv
// ----------------------------------------------------------------------------
// hel_back
// Restoring divider for round(255*num/den) and the output register.
// ----------------------------------------------------------------------------
module hel_back #(
	parameter int COUNT_BITS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  hel_pkg::ctrl_t        pop_ctrl,
	input  logic [COUNT_BITS-1:0] pop_num,
	input  logic [COUNT_BITS-1:0] pop_den,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            level,
	output logic [7:0]            mapped_value,
	output logic                  last_level
);

	localparam int NW    = COUNT_BITS + hel_pkg::SCALE_SH;
	localparam int CNT_W = $clog2(hel_pkg::QBITS);

	hel_pkg::bstate_t      state_q, state_d;
	hel_pkg::ctrl_t        ctrl_q;
	logic [COUNT_BITS-1:0] num_q, den_q;
	logic [NW-1:0]         rem_q, dsr_q;
	logic [7:0]            quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q, out_load, ge;
	logic [7:0]            level_q, mapped_q;
	logic                  last_q;

	assign ge = (rem_q >= dsr_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hel_pkg::B_IDLE: begin
				if (pop_valid) begin
					state_d = (pop_ctrl.kind == hel_pkg::KIND_DIV) ? hel_pkg::B_LOAD
						: hel_pkg::B_DONE;
				end
			end
			hel_pkg::B_LOAD: state_d = hel_pkg::B_CHK;
			hel_pkg::B_CHK:  state_d = ge ? hel_pkg::B_DONE : hel_pkg::B_DIV;
			hel_pkg::B_DIV: begin
				if (cnt_q == '0) state_d = hel_pkg::B_DONE;
			end
			hel_pkg::B_DONE: begin
				if (out_load) state_d = hel_pkg::B_IDLE;
			end
			default: state_d = hel_pkg::B_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		pop_ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			hel_pkg::B_IDLE: pop_ready = 1'b1;
			hel_pkg::B_DONE: out_load  = !out_valid_q || out_ready;
			default: begin
				pop_ready = 1'b0;
				out_load  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hel_pkg::B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == hel_pkg::B_CHK) begin
				cnt_q <= CNT_W'(hel_pkg::QBITS - 1);
			end else if (state_q == hel_pkg::B_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hel_pkg::B_IDLE: begin
				if (pop_valid) begin
					ctrl_q <= pop_ctrl;
					num_q  <= pop_num;
					den_q  <= pop_den;
					quo_q  <= (pop_ctrl.kind == hel_pkg::KIND_SAT) ? hel_pkg::OUT_MAX : 8'd0;
				end
			end
			hel_pkg::B_LOAD: begin
				// dividend 510*num + den, divisor 2*den aligned to quotient bit 8
				rem_q <= {num_q, 9'd0} - {8'd0, num_q, 1'b0} + {9'd0, den_q};
				dsr_q <= {den_q, 9'd0};
			end
			hel_pkg::B_CHK: begin
				if (ge) quo_q <= hel_pkg::OUT_MAX;
				dsr_q <= dsr_q >> 1;
			end
			hel_pkg::B_DIV: begin
				if (ge) rem_q <= rem_q - dsr_q;
				quo_q <= {quo_q[6:0], ge};
				dsr_q <= dsr_q >> 1;
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
		if (out_load) begin
			level_q  <= ctrl_q.level;
			mapped_q <= quo_q;
			last_q   <= ctrl_q.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign level        = level_q;
	assign mapped_value = mapped_q;
	assign last_level   = last_q;

endmodule

FILE: rtl/histogram_equalization_lut_top.sv
// Histogram equalization table generator. Feed one bin count per beat, gray
// levels 0 to NUM_LEVELS-1 in order; each beat gives one table entry
// round(255*(cdf-min)/(pixel_count-min)), saturated at 255, with its level and
// a flag on the last level. An entry that needs a division passes through the
// back-end divider as take, load, saturation test, 8 restoring steps and
// hand-off, skipping the restoring steps when the saturation test already
// fires; a zero or saturated entry goes through take and hand-off only. The
// front end takes a new beat every cycle while the two-entry queue has room;
// the divider takes a new entry only after handing off the last one.
// pixel_count is latched on cfg_wr_en, then sampled as each bin is taken.
// ----------------------------------------------------------------------------
// histogram_equalization_lut_top
// Cumulative-histogram to equalization table, front end, queue and divider.
// ----------------------------------------------------------------------------
module histogram_equalization_lut_top #(
	parameter int NUM_LEVELS = 256,
	parameter int COUNT_BITS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [COUNT_BITS-1:0] pixel_count,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COUNT_BITS-1:0] bin_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            level,
	output logic [7:0]            mapped_value,
	output logic                  last_level
);

	logic [COUNT_BITS-1:0] pixel_count_q;
	logic                  push_valid, push_ready, pop_valid, pop_ready;
	hel_pkg::ctrl_t        push_ctrl, pop_ctrl;
	logic [COUNT_BITS-1:0] push_num, push_den, pop_num, pop_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
		end else if (cfg_wr_en) begin
			pixel_count_q <= pixel_count;
		end
	end

	hel_front #(
		.NUM_LEVELS (NUM_LEVELS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.bin_count   (bin_count),
		.pixel_count (pixel_count_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_ctrl   (push_ctrl),
		.push_num    (push_num),
		.push_den    (push_den)
	);

	hel_queue #(
		.DATA_W (COUNT_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.push_num   (push_num),
		.push_den   (push_den),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_ctrl   (pop_ctrl),
		.pop_num    (pop_num),
		.pop_den    (pop_den)
	);

	hel_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_ctrl     (pop_ctrl),
		.pop_num      (pop_num),
		.pop_den      (pop_den),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level        (level),
		.mapped_value (mapped_value),
		.last_level   (last_level)
	);

endmodule

FILE: rtl/hel_checker.sv
// ----------------------------------------------------------------------------
// hel_checker
// Port-level checks on the result channel of the table generator.
// ----------------------------------------------------------------------------
`include "histogram_equalization_lut_top_assert.svh"

module hel_checker #(
	parameter int NUM_LEVELS = 256
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] level,
	input logic [7:0] mapped_value,
	input logic       last_level
);

	localparam logic [7:0] LVL_LAST = 8'((NUM_LEVELS - 1) % 256);

	// hold a stalled beat
	`HEL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(level) && $stable(mapped_value) && $stable(last_level), "result beat changed while stalled")

	// the last flag rides only on the final level
	`HEL_ASSERT_SAME(a_last_level, out_valid && last_level, level == LVL_LAST, "last_level on wrong level")

	// level zero is either before the minimum or at it: always maps to zero
	`HEL_ASSERT_SAME(a_level_zero, out_valid && (level == 8'd0) && (NUM_LEVELS <= 256), mapped_value == 8'd0, "level zero mapped to nonzero")

endmodule

bind histogram_equalization_lut_top hel_checker #(
	.NUM_LEVELS (NUM_LEVELS)
) u_hel_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level        (level),
	.mapped_value (mapped_value),
	.last_level   (last_level)
);

FILE: tb/histogram_equalization_lut_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_equalization_lut_top_tb
// Feeds whole 256-level histograms (well-formed, single-bin, over-counted,
// noisy and empty ones) behind a short directed opening. It predicts every
// table entry from a cycle-free copy of the cumulative-sum logic and checks
// each output beat in order, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module histogram_equalization_lut_top_tb;

	localparam int NUM_LEVELS = 256;
	localparam int COUNT_BITS = 25;
	localparam logic [COUNT_BITS-1:0] COUNT_ALL = '1;

	typedef enum {
		HIST_NORMAL,
		HIST_SINGLE,
		HIST_OVER,
		HIST_NOISE,
		HIST_EMPTY
	} hist_kind_t;

	typedef struct packed {
		logic [7:0] level;
		logic [7:0] value;
		logic       last;
	} entry_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [COUNT_BITS-1:0] pixel_count = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [COUNT_BITS-1:0] bin_count = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            level;
	logic [7:0]            mapped_value;
	logic                  last_level;

	// Bins waiting for the driver, and table entries owed by the block
	logic [COUNT_BITS-1:0] bins_pending[$];
	entry_t                entries_due[$];
	logic [COUNT_BITS-1:0] hist[NUM_LEVELS];

	// Shadow of the block's state
	logic [COUNT_BITS-1:0] pc_shadow = '0;
	logic [COUNT_BITS-1:0] cdf_sum = '0;
	logic [COUNT_BITS-1:0] cdf_min = '0;
	logic                  cdf_seen = 1'b0;
	int unsigned           cur_level = 0;

	int unsigned gen_level = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned rdy_tick = 0;
	int unsigned rdy_mode = 0;
	int unsigned errors = 0;
	int unsigned beats_in = 0;
	int unsigned beats_out = 0;
	int unsigned sat_entries = 0;
	int unsigned zero_entries = 0;
	int unsigned cfg_writes = 0;
	int unsigned tables_sent = 0;
	entry_t      want;

	histogram_equalization_lut_top #(
		.NUM_LEVELS(NUM_LEVELS),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.pixel_count(pixel_count),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bin_count(bin_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level),
		.mapped_value(mapped_value),
		.last_level(last_level)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the cumulative sum by one bin and work out its table entry
	function automatic entry_t table_entry_for(input logic [COUNT_BITS-1:0] bin);
		entry_t      e;
		bit [63:0]   acc;
		bit [63:0]   num;
		bit [63:0]   den;
		bit [63:0]   q;

		acc = 64'(cdf_sum) + 64'(bin);
		cdf_sum = (acc > 64'(COUNT_ALL)) ? COUNT_ALL : acc[COUNT_BITS-1:0];
		if (!cdf_seen && cdf_sum != 0) begin
			cdf_seen = 1'b1;
			cdf_min = cdf_sum;
		end
		e.level = cur_level[7:0];
		e.last = (cur_level == NUM_LEVELS - 1);
		num = 64'(cdf_sum) - 64'(cdf_min);
		if (!cdf_seen || pc_shadow == cdf_min || num == 0) begin
			e.value = 8'd0;
		end else if (pc_shadow < cdf_min) begin
			e.value = hel_pkg::OUT_MAX;
		end else begin
			den = 64'(pc_shadow) - 64'(cdf_min);
			q = (64'd510 * num + den) / (64'd2 * den);
			e.value = (q > 64'(hel_pkg::OUT_MAX)) ? hel_pkg::OUT_MAX : q[7:0];
		end
		if (e.last) begin
			cdf_sum = '0;
			cdf_min = '0;
			cdf_seen = 1'b0;
			cur_level = 0;
		end else begin
			cur_level++;
		end
		return e;
	endfunction

	// Driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			bin_count <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				entries_due.insert(entries_due.size(), table_entry_for(bin_count));
				beats_in++;
			end
			if (in_valid && !in_ready) begin
				// hold the beat until taken
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (bins_pending.size() != 0) begin
				in_valid <= 1'b1;
				bin_count <= bins_pending.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result beat, and stall the sink in changing modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				beats_out++;
				if (entries_due.size() == 0) begin
					$error("result beat for level %0d with nothing expected", level);
					errors++;
				end else begin
					want = entries_due.pop_front();
					if (level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, level);
						errors++;
					end
					if (mapped_value !== want.value) begin
						$error("mapped_value: expected %0d, got %0d", want.value,
							mapped_value);
						errors++;
					end
					if (last_level !== want.last) begin
						$error("last_level: expected %0d, got %0d", want.last, last_level);
						errors++;
					end
					if (want.value == hel_pkg::OUT_MAX)
						sat_entries++;
					if (want.value == 8'd0)
						zero_entries++;
				end
			end
			rdy_tick++;
			if (rdy_tick % 64 == 0)
				rdy_mode = $urandom_range(0, 2);
			case (rdy_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= (rdy_tick % 4 == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic queue_bin(input logic [COUNT_BITS-1:0] v);
		bins_pending.insert(bins_pending.size(), v);
		gen_level = (gen_level + 1) % NUM_LEVELS;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (bins_pending.size() != 0 || in_valid || entries_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_pixel_count(input logic [COUNT_BITS-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		pixel_count <= v;
		pc_shadow = v;
		cfg_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Fill hist[] with one image's histogram and pick the pixel count to go with it
	task automatic fill_image_hist(input hist_kind_t kind,
		output logic [COUNT_BITS-1:0] pc);
		longint unsigned total;
		longint unsigned wsum;
		longint unsigned acc;
		longint unsigned lowest;
		int unsigned     w[NUM_LEVELS];
		int              lz;
		int              tz;
		int              first;

		foreach (hist[i])
			hist[i] = '0;
		pc = '0;
		case (kind)
			HIST_NORMAL, HIST_OVER: begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: total = 64'($urandom_range(256, 4096));
					5, 6, 7: total = 64'($urandom_range(4097, 1 << 20));
					default: total = 64'($urandom_range(1, 1 << 24));
				endcase
				lz = $urandom_range(0, 120);
				tz = $urandom_range(0, 120);
				wsum = 0;
				foreach (w[i]) begin
					if (i < lz || i >= NUM_LEVELS - tz || $urandom_range(0, 3) == 0)
						w[i] = 0;
					else
						w[i] = $urandom_range(1, 255);
					wsum += 64'(w[i]);
				end
				if (wsum == 0) begin
					w[lz] = 1;
					wsum = 1;
				end
				acc = 0;
				first = -1;
				foreach (w[i]) begin
					hist[i] = COUNT_BITS'((total * 64'(w[i])) / wsum);
					acc += 64'(hist[i]);
					if (first < 0 && w[i] != 0)
						first = i;
				end
				// put the rounding remainder on the darkest populated level
				hist[first] = COUNT_BITS'(64'(hist[first]) + (total - acc));
				pc = COUNT_BITS'(total);
				if (kind == HIST_OVER) begin
					lowest = 0;
					foreach (hist[i])
						if (lowest == 0)
							lowest = 64'(hist[i]);
					if ($urandom_range(0, 1) == 0 && lowest > 1)
						pc = COUNT_BITS'($urandom_range(0, 32'(lowest - 1)));
					else if (total - 1 > lowest)
						pc = COUNT_BITS'($urandom_range(32'(lowest), 32'(total - 1)));
					else
						pc = COUNT_BITS'(lowest);
				end
			end
			HIST_SINGLE: begin
				total = ($urandom_range(0, 3) == 0) ? 64'(COUNT_ALL)
					: 64'($urandom_range(1, 1 << 24));
				hist[$urandom_range(0, NUM_LEVELS - 1)] = COUNT_BITS'(total);
				pc = COUNT_BITS'(total);
			end
			HIST_NOISE: begin
				foreach (hist[i])
					case ($urandom_range(0, 3))
						0: hist[i] = '0;
						1: hist[i] = COUNT_BITS'($urandom_range(0, 15));
						2: hist[i] = COUNT_BITS'($urandom_range(0, 1 << 24));
						default: hist[i] = COUNT_BITS'($urandom);
					endcase
				pc = COUNT_BITS'($urandom);
			end
			default: pc = '0;
		endcase
	endtask

	initial begin
		hist_kind_t            plan[6];
		logic [COUNT_BITS-1:0] pc;

		plan = '{HIST_NORMAL, HIST_SINGLE, HIST_OVER, HIST_NORMAL, HIST_NOISE, HIST_EMPTY};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening, pixel count still at its reset value of zero:
		// leading empty bins, then the minimum bin, then a count above pixels
		queue_bin('0);
		queue_bin('0);
		queue_bin(25'd5);
		queue_bin(25'd3);
		wait_idle();
		// full-scale pixel count, then drive the running sum into saturation
		write_pixel_count(COUNT_ALL);
		queue_bin(25'd1);
		queue_bin(COUNT_ALL);
		queue_bin(25'd9);
		wait_idle();
		// pixel count equal to the minimum
		write_pixel_count(25'd5);
		queue_bin(25'd4);
		queue_bin('0);
		wait_idle();
		// one pixel above the minimum: quotient far beyond full scale
		write_pixel_count(25'd6);
		queue_bin('0);
		wait_idle();
		write_pixel_count(25'd1000);
		while (gen_level != 0)
			queue_bin(COUNT_BITS'($urandom_range(0, 3)));
		tables_sent++;

		foreach (plan[t]) begin
			fill_image_hist(plan[t], pc);
			// let the previous table drain before the count changes
			wait_idle();
			write_pixel_count(pc);
			foreach (hist[i])
				queue_bin(hist[i]);
			tables_sent++;
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("Covered %0d tables: %0d bin beats in, %0d entries out, %0d count writes",
			tables_sent, beats_in, beats_out, cfg_writes);
		$display("Entries at full scale: %0d, entries at zero: %0d", sat_entries,
			zero_entries);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
